/* src/isz_pkg.sv */
`default_nettype none

package isz_pkg;

   localparam int POS_BITS     = 32;
   localparam int HEADER_BYTES = 24;
   localparam int HDR_IDX_BITS = $clog2(HEADER_BYTES);
   localparam int SCRATCH_BYTES = 8;
   localparam int SCR_IDX_BITS  = $clog2(SCRATCH_BYTES);

   localparam logic [POS_BITS-1:0] POS_MAX   = '1;
   localparam logic [POS_BITS-1:0] POS_LIMIT = POS_MAX - POS_BITS'(8);
   localparam logic [POS_BITS-1:0] SEG_END_RESET = POS_BITS'(2);
   localparam logic [POS_BITS-1:0] HDR_LAST_POS  = POS_BITS'(HEADER_BYTES - 1);

   localparam logic [3:0] SEG_MARK_OFS = 4'd0;
   localparam logic [3:0] SEG_LEN_OFS  = 4'd3;
   localparam logic [3:0] SEG_LAST_OFS = 4'd8;
   localparam logic [POS_BITS-1:0] SEG_MAX_OFS = POS_BITS'(8);

   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_SOI  = 8'hD8;
   localparam logic [7:0] BYTE_APP0 = 8'hE0;
   localparam logic [7:0] BYTE_PNG0 = 8'h89;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_LF   = 8'h0A;
   localparam logic [7:0] BYTE_SUB  = 8'h1A;

   localparam logic [1:0] FMT_NONE = 2'd0;
   localparam logic [1:0] FMT_JPEG = 2'd1;
   localparam logic [1:0] FMT_GIF  = 2'd2;
   localparam logic [1:0] FMT_PNG  = 2'd3;

   typedef enum logic [1:0] {
      PHASE_COLLECT,
      PHASE_JPEG,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      WALK_RUN,
      WALK_FOUND,
      WALK_LOST
   } walk_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  image_format;
      logic [31:0] width;
      logic [31:0] height;
   } result_type;

   function automatic logic is_frame_marker(input logic [7:0] m);
      return (m inside {[8'hC0:8'hC3], [8'hC9:8'hCB]});
   endfunction

endpackage

`default_nettype wire

/* src/isz_parse.sv */
`default_nettype none

module isz_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [7:0]          file_byte,
   input  wire logic                end_of_file,
   output      logic                emit,
   output      isz_pkg::result_type result
);
   import isz_pkg::*;

   phase_type             phase_ff, phase_in;
   walk_type              walk_ff, walk_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   seg_end_ff, seg_end_in;
   logic [15:0]           jw_ff, jw_in;
   logic [15:0]           jh_ff, jh_in;
   logic [7:0]            hdr_ff [HEADER_BYTES];
   logic [7:0]            scr_ff [SCRATCH_BYTES];

   logic [7:0]            h [HEADER_BYTES];
   logic                  at_seg;
   logic [POS_BITS-1:0]   gap;
   logic                  near;
   logic [3:0]            ofs;
   logic [15:0]           seg_len;
   logic [POS_BITS:0]     seg_sum;
   logic                  seg_over;
   walk_type              step_status;
   logic                  do_walk;
   logic                  is_png, is_gif, is_jfif;

   assign at_seg  = pos_ff >= seg_end_ff;
   assign gap     = pos_ff - seg_end_ff;
   assign near    = gap <= SEG_MAX_OFS;
   assign ofs     = gap[3:0];
   assign seg_len = {scr_ff[2], file_byte};
   assign seg_sum = (POS_BITS+1)'(seg_end_ff) + (POS_BITS+1)'(seg_len) + (POS_BITS+1)'(2);
   assign seg_over = (seg_end_ff > POS_LIMIT) || (seg_sum > {1'b0, POS_LIMIT});

   always_comb begin
      step_status = WALK_RUN;
      if (at_seg) begin
         if (!near) begin
            step_status = WALK_LOST;
         end else begin
            case (ofs)
               SEG_MARK_OFS: begin
                  if (file_byte != BYTE_FF) step_status = WALK_LOST;
               end
               SEG_LEN_OFS: begin
                  if (!is_frame_marker(scr_ff[1]) && (seg_len < 16'd2 || seg_over))
                     step_status = WALK_LOST;
               end
               SEG_LAST_OFS: step_status = WALK_FOUND;
               default: step_status = WALK_RUN;
            endcase
         end
      end
   end

   always_comb begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) h[i] = hdr_ff[i];
      h[HEADER_BYTES-1] = file_byte;
   end

   assign is_png = h[0] == BYTE_PNG0 && h[1] == "P" && h[2] == "N" && h[3] == "G" &&
                   h[4] == BYTE_CR && h[5] == BYTE_LF && h[6] == BYTE_SUB &&
                   h[7] == BYTE_LF && h[12] == "I" && h[13] == "H" &&
                   h[14] == "D" && h[15] == "R";
   assign is_gif = h[0] == "G" && h[1] == "I" && h[2] == "F";
   assign is_jfif = h[0] == BYTE_FF && h[1] == BYTE_SOI && h[2] == BYTE_FF &&
                    h[3] == BYTE_APP0 && h[6] == "J" && h[7] == "F" &&
                    h[8] == "I" && h[9] == "F";

   assign do_walk = (walk_ff == WALK_RUN) &&
                    ((phase_ff == PHASE_JPEG) ||
                     (phase_ff == PHASE_COLLECT && pos_ff > POS_BITS'(1)));

   always_comb begin
      phase_in   = phase_ff;
      walk_in    = walk_ff;
      pos_in     = pos_ff;
      seg_end_in = seg_end_ff;
      jw_in      = jw_ff;
      jh_in      = jh_ff;
      emit       = 1'b0;
      result     = '0;
      if (take) begin
         if (do_walk) begin
            walk_in = step_status;
            if (at_seg && near && ofs == SEG_LEN_OFS && step_status == WALK_RUN &&
                !is_frame_marker(scr_ff[1]))
               seg_end_in = seg_sum[POS_BITS-1:0];
            if (step_status == WALK_FOUND) begin
               jh_in = {scr_ff[5], scr_ff[6]};
               jw_in = {scr_ff[7], file_byte};
            end
         end
         case (phase_ff)
            PHASE_COLLECT: begin
               if (pos_ff == HDR_LAST_POS) begin
                  if (is_png) begin
                     emit   = 1'b1;
                     result = '{1'b1, FMT_PNG, {h[16], h[17], h[18], h[19]},
                                {h[20], h[21], h[22], h[23]}};
                  end else if (is_gif) begin
                     emit   = 1'b1;
                     result = '{1'b1, FMT_GIF, {16'd0, h[7], h[6]}, {16'd0, h[9], h[8]}};
                  end else if (is_jfif) begin
                     if (walk_in == WALK_FOUND) begin
                        emit   = 1'b1;
                        result = '{1'b1, FMT_JPEG, {16'd0, jw_in}, {16'd0, jh_in}};
                     end else if (walk_in == WALK_LOST) begin
                        emit = 1'b1;
                     end else begin
                        phase_in = PHASE_JPEG;
                     end
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
            PHASE_JPEG: begin
               if (walk_in == WALK_FOUND) begin
                  emit   = 1'b1;
                  result = '{1'b1, FMT_JPEG, {16'd0, jw_in}, {16'd0, jh_in}};
               end else if (walk_in == WALK_LOST) begin
                  emit = 1'b1;
               end
            end
            default: ;
         endcase
         if (emit) phase_in = PHASE_DONE;
         if (end_of_file) begin
            if (phase_ff != PHASE_DONE && !emit) begin
               emit   = 1'b1;
               result = '0;
            end
            phase_in   = PHASE_COLLECT;
            walk_in    = WALK_RUN;
            pos_in     = '0;
            seg_end_in = SEG_END_RESET;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_COLLECT;
         walk_ff    <= WALK_RUN;
         pos_ff     <= '0;
         seg_end_ff <= SEG_END_RESET;
      end else begin
         phase_ff   <= phase_in;
         walk_ff    <= walk_in;
         pos_ff     <= pos_in;
         seg_end_ff <= seg_end_in;
      end
   end

   always_ff @(posedge clock) begin
      jw_ff <= jw_in;
      jh_ff <= jh_in;
      if (take && phase_ff == PHASE_COLLECT && pos_ff < POS_BITS'(HEADER_BYTES))
         hdr_ff[pos_ff[HDR_IDX_BITS-1:0]] <= file_byte;
      if (take && do_walk && at_seg && gap < POS_BITS'(SCRATCH_BYTES))
         scr_ff[gap[SCR_IDX_BITS-1:0]] <= file_byte;
   end

endmodule

`default_nettype wire

/* src/image_header_size_sniffer.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_file_byte, req_end_of_file
// rsp      out        rsp_valid/rsp_ready    rsp_found, rsp_image_format, rsp_width, rsp_height
//
// One byte is accepted per cycle while req_ready is high; its result, if any, is registered for rsp.
// The parse state updates in a single pass from the request byte to the result register.
// A skid register behind the result register lets one more result in while rsp stalls;
// req_ready drops only while both hold a result.
// Synchronous active-high reset returns to header collect at offset zero.
`default_nettype none

module image_header_size_sniffer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_file_byte,
   input  wire logic        req_end_of_file,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_found,
   output      logic [1:0]  rsp_image_format,
   output      logic [31:0] rsp_width,
   output      logic [31:0] rsp_height
);
   import isz_pkg::*;

   logic       take;
   logic       emit;
   result_type result;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   isz_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .file_byte   (req_file_byte),
      .end_of_file (req_end_of_file),
      .emit        (emit),
      .result      (result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = take && emit;
         end
      end else if (take && emit) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_ff.found;
   assign rsp_image_format = out_ff.image_format;
   assign rsp_width        = out_ff.width;
   assign rsp_height       = out_ff.height;

endmodule

`default_nettype wire

/* src/isz_checker.sv */
`default_nettype none

module isz_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [1:0]  rsp_image_format,
   input wire logic [31:0] rsp_width,
   input wire logic [31:0] rsp_height
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_width) && $stable(rsp_height))
      else $error("stalled response changed");

   // drop to idle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_image_format == 2'd0 && rsp_width == 32'd0 &&
                                  rsp_height == 32'd0)
      else $error("not-found response carries data");

   a_found_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_image_format != 2'd0)
      else $error("found response without format");

endmodule

bind image_header_size_sniffer isz_checker u_isz_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_image_format (rsp_image_format),
   .rsp_width        (rsp_width),
   .rsp_height       (rsp_height)
);

`default_nettype wire

/* dv/image_size_checker.sv */
module image_size_checker
   import isz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_end_of_file,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [1:0]  rsp_image_format,
   input  logic [31:0] rsp_width,
   input  logic [31:0] rsp_height,
   output int          reports_pending,
   output int          mismatch_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  SOF_LOW_FIRST  = 8'hC0;
   localparam logic [7:0]  SOF_LOW_LAST   = 8'hC3;
   localparam logic [7:0]  SOF_HIGH_FIRST = 8'hC9;
   localparam logic [7:0]  SOF_HIGH_LAST  = 8'hCB;
   localparam int          MARK_OFS       = 0;
   localparam int          LEN_OFS        = 3;
   localparam int          FRAME_OFS      = 8;
   localparam int          WALK_START     = 2;
   localparam logic [31:0] JFIF_TAG       = "JFIF";
   localparam logic [31:0] IHDR_TAG       = "IHDR";
   localparam logic [23:0] GIF_TAG        = "GIF";
   localparam logic [63:0] PNG_SIG        = {BYTE_PNG0, "PNG", BYTE_CR, BYTE_LF, BYTE_SUB, BYTE_LF};
   localparam logic [31:0] JPEG_START     = {BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_APP0};

   logic [POS_BITS-1:0] position;
   logic [7:0]          hdr [HEADER_BYTES];
   longint unsigned     seg_end;
   phase_type           phase;
   logic                reported;
   walk_type            walk;
   logic [7:0]          seg_bytes [FRAME_OFS+1];
   logic [31:0]         jpeg_width;
   logic [31:0]         jpeg_height;

   result_type size_reports_due [$];
   int         fails = 0;

   assign mismatch_count = fails;

   function automatic void restart();
      position    = '0;
      seg_end     = SEG_END_RESET;
      phase       = PHASE_COLLECT;
      reported    = 1'b0;
      walk        = WALK_RUN;
      jpeg_width  = '0;
      jpeg_height = '0;
   endfunction

   function automatic bit starts_frame(input logic [7:0] m);
      return (m >= SOF_LOW_FIRST && m <= SOF_LOW_LAST) ||
             (m >= SOF_HIGH_FIRST && m <= SOF_HIGH_LAST);
   endfunction

   function automatic walk_type walk_segment(input longint unsigned at, input logic [7:0] b);
      longint unsigned ofs;
      longint unsigned seg_len;
      if (at < seg_end) return WALK_RUN;
      ofs = at - seg_end;
      if (ofs > FRAME_OFS) return WALK_LOST;
      seg_bytes[ofs] = b;
      if (ofs == MARK_OFS) return (b == BYTE_FF) ? WALK_RUN : WALK_LOST;
      if (ofs == LEN_OFS && !starts_frame(seg_bytes[1])) begin
         seg_len = {seg_bytes[2], seg_bytes[3]};
         if (seg_len < 2) return WALK_LOST;
         if (seg_end > POS_LIMIT || seg_len + 2 > POS_LIMIT - seg_end) return WALK_LOST;
         seg_end += seg_len + 2;
         return WALK_RUN;
      end
      if (ofs == FRAME_OFS) begin
         jpeg_height = {seg_bytes[5], seg_bytes[6]};
         jpeg_width  = {seg_bytes[7], seg_bytes[8]};
         return WALK_FOUND;
      end
      return WALK_RUN;
   endfunction

   function automatic result_type finish_file(input logic hit, input logic [1:0] fmt,
                                              input logic [31:0] w, input logic [31:0] h);
      reported = 1'b1;
      phase    = PHASE_DONE;
      return {hit, fmt, w, h};
   endfunction

   function automatic bit classify_header(output result_type r);
      r = '0;
      if ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]} == PNG_SIG &&
          {hdr[12], hdr[13], hdr[14], hdr[15]} == IHDR_TAG) begin
         r = finish_file(1'b1, FMT_PNG, {hdr[16], hdr[17], hdr[18], hdr[19]},
                         {hdr[20], hdr[21], hdr[22], hdr[23]});
         return 1'b1;
      end
      if ({hdr[0], hdr[1], hdr[2]} == GIF_TAG) begin
         r = finish_file(1'b1, FMT_GIF, {hdr[7], hdr[6]}, {hdr[9], hdr[8]});
         return 1'b1;
      end
      if ({hdr[0], hdr[1], hdr[2], hdr[3]} == JPEG_START &&
          {hdr[6], hdr[7], hdr[8], hdr[9]} == JFIF_TAG) begin
         if (walk == WALK_FOUND) begin
            r = finish_file(1'b1, FMT_JPEG, jpeg_width, jpeg_height);
            return 1'b1;
         end
         if (walk == WALK_LOST) begin
            r = finish_file(1'b0, FMT_NONE, '0, '0);
            return 1'b1;
         end
         phase = PHASE_JPEG;
         return 1'b0;
      end
      r = finish_file(1'b0, FMT_NONE, '0, '0);
      return 1'b1;
   endfunction

   function automatic bit sniff_byte(input logic [7:0] b, input logic eof,
                                     output result_type r);
      longint unsigned at;
      bit              hit;
      at  = position;
      hit = 1'b0;
      r   = '0;
      if (phase == PHASE_COLLECT) begin
         if (at < HEADER_BYTES) hdr[at] = b;
         if (walk == WALK_RUN && at >= WALK_START) walk = walk_segment(at, b);
         if (at == HEADER_BYTES - 1) hit = classify_header(r);
      end else if (phase == PHASE_JPEG) begin
         if (walk == WALK_RUN) walk = walk_segment(at, b);
         if (walk == WALK_FOUND) begin
            r   = finish_file(1'b1, FMT_JPEG, jpeg_width, jpeg_height);
            hit = 1'b1;
         end else if (walk == WALK_LOST) begin
            r   = finish_file(1'b0, FMT_NONE, '0, '0);
            hit = 1'b1;
         end
      end
      if (eof) begin
         if (!reported && !hit) begin
            r   = finish_file(1'b0, FMT_NONE, '0, '0);
            hit = 1'b1;
         end
         restart();
      end else if (position < POS_MAX) begin
         position++;
      end
      return hit;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : track
      result_type got;
      result_type want;
      result_type made;
      if (reset) begin
         restart();
         size_reports_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_found, rsp_image_format, rsp_width, rsp_height};
            if (size_reports_due.size() == 0) begin
               $display("%0t: unexpected result, expected none got %0h", $time, got);
               fails++;
            end else begin
               want = size_reports_due.pop_front();
               check_field("found", want.found, got.found);
               check_field("image_format", want.image_format, got.image_format);
               check_field("width", want.width, got.width);
               check_field("height", want.height, got.height);
            end
         end
         if (req_valid && req_ready && sniff_byte(req_file_byte, req_end_of_file, made))
            size_reports_due.push_back(made);
      end
      reports_pending = size_reports_due.size();
   end

endmodule

/* dv/image_header_size_sniffer_tb.sv */
module image_header_size_sniffer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import isz_pkg::*;

   localparam int         STALL_LIMIT   = 4000;
   localparam int         RANDOM_BYTES  = 560;
   localparam int         RANDOM_FILES  = 20;
   localparam int         PHASE_FILES   = 5;
   localparam logic [7:0] FRAME_MARKERS [7] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3,
                                                8'hC9, 8'hCA, 8'hCB};
   localparam logic [7:0] OTHER_MARKERS [10] = '{8'hC4, 8'hC8, 8'hCC, 8'hBF, 8'hDB,
                                                 8'hDD, 8'hE1, 8'hFE, 8'hFF, 8'h00};

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_file_byte   = '0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_found;
   logic [1:0]  rsp_image_format;
   logic [31:0] rsp_width;
   logic [31:0] rsp_height;
   int          reports_pending;
   int          mismatch_count;

   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   logic [7:0]  file_bytes [$];

   image_header_size_sniffer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_file_byte    (req_file_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_image_format (rsp_image_format),
      .rsp_width        (rsp_width),
      .rsp_height       (rsp_height)
   );

   image_size_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_file_byte    (req_file_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_image_format (rsp_image_format),
      .rsp_width        (rsp_width),
      .rsp_height       (rsp_height),
      .reports_pending  (reports_pending),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void put_be(input logic [63:0] v, input int n);
      for (int k = n - 1; k >= 0; k--) file_bytes.push_back(v[8*k +: 8]);
   endfunction

   function automatic void put_le(input logic [63:0] v, input int n);
      for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
   endfunction

   function automatic void put_random(input int n);
      for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void trim_file(input int n);
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
   endfunction

   function automatic void build_png(input logic [31:0] w, input logic [31:0] h, input int tail);
      put_be({BYTE_PNG0, "PNG", BYTE_CR, BYTE_LF, BYTE_SUB, BYTE_LF}, 8);
      put_be($urandom, 4);
      put_be("IHDR", 4);
      put_be(w, 4);
      put_be(h, 4);
      put_random(tail);
   endfunction

   function automatic void build_gif(input bit v89, input logic [15:0] w, input logic [15:0] h,
                                     input int tail);
      put_be("GIF", 3);
      put_be(v89 ? "89a" : "87a", 3);
      put_le(w, 2);
      put_le(h, 2);
      put_random(HEADER_BYTES - 10 + tail);
   endfunction

   function automatic void build_jpeg(input int app_len, input int segs,
                                      input logic [7:0] frame_code, input logic [15:0] h,
                                      input logic [15:0] w, input int tail);
      int seg_len;
      put_be({BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_APP0}, 4);
      put_be(app_len, 2);
      put_be({"JFIF", 8'h00}, 5);
      put_random(app_len - 7);
      for (int s = 0; s < segs; s++) begin
         put_be({BYTE_FF, OTHER_MARKERS[$urandom_range(9)]}, 2);
         seg_len = ($urandom_range(19) == 0) ? $urandom_range(1) : $urandom_range(2, 10);
         put_be(seg_len, 2);
         put_random((seg_len > 2) ? seg_len - 2 : 0);
      end
      put_be({BYTE_FF, frame_code}, 2);
      put_be($urandom_range(65535), 2);
      put_random(1);
      put_be(h, 2);
      put_be(w, 2);
      put_random(tail);
   endfunction

   function automatic void build_random_file();
      int shape;
      shape = $urandom_range(99);
      if (shape < 90) begin
         case ($urandom_range(3))
            0: build_png($urandom, $urandom, $urandom_range(6));
            1: build_gif($urandom_range(1), $urandom, $urandom, $urandom_range(6));
            default: build_jpeg($urandom_range(8, 20), $urandom_range(2),
                                FRAME_MARKERS[$urandom_range(6)], $urandom, $urandom,
                                $urandom_range(6));
         endcase
         if (shape >= 60 && shape < 75)
            trim_file($urandom_range(1, file_bytes.size()));
         else if (shape >= 75)
            file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom_range(255));
      end else begin
         put_random($urandom_range(1, 40));
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_file_byte   <= b;
      req_end_of_file <= eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int k = 0; k < file_bytes.size(); k++)
         push_byte(file_bytes[k], k == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   initial begin : stimulus
      int made_bytes;
      int made_files;
      made_bytes = 0;
      made_files = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_random(1);
      send_file();
      build_png(32'hFFFF_FFFF, 32'h0, 3);
      send_file();
      build_png(32'h0, 32'hFFFF_FFFF, 0);
      send_file();
      build_gif(1'b1, 16'hFFFF, 16'h0, 0);
      send_file();
      build_gif(1'b0, 16'h0, 16'hFFFF, 4);
      send_file();
      build_jpeg(8, 0, FRAME_MARKERS[0], 16'hFFFF, 16'h0001, 0);
      send_file();
      build_jpeg(16, 1, FRAME_MARKERS[6], 16'h0, 16'hFFFF, 2);
      send_file();
      // file ends before the frame header is complete
      build_jpeg(20, 2, FRAME_MARKERS[3], 16'h1234, 16'h5678, 0);
      trim_file(30);
      send_file();
      // APP1 instead of the JFIF APP0
      build_jpeg(16, 0, FRAME_MARKERS[1], 16'h0100, 16'h0200, 0);
      file_bytes[3] = 8'hE1;
      send_file();
      // no marker prefix where a segment is due
      build_jpeg(16, 0, FRAME_MARKERS[2], 16'h0100, 16'h0200, 0);
      file_bytes[20] = 8'h00;
      send_file();
      // segment lengths zero and one
      build_jpeg(16, 1, FRAME_MARKERS[4], 16'h0100, 16'h0200, 0);
      file_bytes[22] = 8'h00;
      file_bytes[23] = 8'h00;
      send_file();
      build_jpeg(8, 1, FRAME_MARKERS[5], 16'h0100, 16'h0200, 3);
      file_bytes[14] = 8'h00;
      file_bytes[15] = 8'h01;
      send_file();
      put_be('0, 8);
      put_be('0, 8);
      put_be('0, 8);
      put_random(5);
      send_file();
      build_png(32'h10, 32'h20, 0);
      trim_file(10);
      send_file();
      repeat (30) put_be(BYTE_FF, 1);
      send_file();

      while (made_bytes < RANDOM_BYTES || made_files < RANDOM_FILES) begin
         case ((made_files / PHASE_FILES) % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin req_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         build_random_file();
         made_bytes += file_bytes.size();
         made_files++;
         send_file();
      end

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (reports_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
